// ----- rtl/fvp_pkg.sv -----
// ----------------------------------------------------------------------------
// FOC voltage to PWM package
// Transaction types, sine polynomial constants and the Q30 multiply helper.
// ----------------------------------------------------------------------------
package fvp_pkg;

   // Taylor coefficients of sin(pi/2 * x) in Q30.
   localparam logic signed [31:0] C1        = 32'sd1686629713;
   localparam logic signed [31:0] C3        = -32'sd693598668;
   localparam logic signed [31:0] C5        = 32'sd85569306;
   localparam logic signed [31:0] C7        = -32'sd5026995;
   localparam logic signed [31:0] C9        = 32'sd172272;
   localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
   localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
   localparam logic [31:0]        QUARTER   = 32'h4000_0000;
   localparam int                 QMAX      = 16;

   typedef struct packed {
      logic signed [15:0] torque_voltage;
      logic [15:0]        electrical_angle;
   } req_type;

   typedef struct packed {
      logic [11:0] compare_a;
      logic [11:0] compare_b;
      logic [11:0] compare_c;
   } rsp_type;

   // One sine evaluation in flight: folded argument, its square and the sum.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] x2;
      logic signed [31:0] p;
      logic               neg;
   } lane_type;

   typedef struct packed {
      logic signed [17:0] v;
      lane_type           sl;
      lane_type           cl;
   } horn_type;

   // Three phase divisions in flight: partial remainders and quotients.
   typedef struct packed {
      logic [2:0][31:0]   r;
      logic [2:0][QMAX-1:0] q;
   } div_type;

   // Product of two signed values scaled by 2^-30, truncated toward zero.
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic        neg;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] pr;
      logic [31:0] r;
      neg = a[31] ^ b[31];
      ma  = a[31] ? (~a + 32'd1) : a;
      mb  = b[31] ? (~b + 32'd1) : b;
      pr  = {32'b0, ma} * {32'b0, mb};
      r   = pr[61:30];
      return neg ? $signed(~r + 32'd1) : $signed(r);
   endfunction

endpackage

// ----- rtl/fvp_horner_cell.sv -----
// ----------------------------------------------------------------------------
// FOC voltage to PWM Horner cell
// One step of the sine polynomial for both the sine and cosine lanes.
// ----------------------------------------------------------------------------
module fvp_horner_cell import fvp_pkg::*; #(
   parameter logic signed [31:0] COEF = 32'sd0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  horn_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output horn_type out_data
);

   logic     valid_ff;
   horn_type data_ff;
   horn_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // Add the coefficient to the running sum times x squared.
   always_comb begin
      data_in      = in_data;
      data_in.sl.p = COEF + mul_q30(in_data.sl.p, in_data.sl.x2);
      data_in.cl.p = COEF + mul_q30(in_data.cl.p, in_data.cl.x2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/fvp_div_cell.sv -----
// ----------------------------------------------------------------------------
// FOC voltage to PWM divider cell
// One restoring quotient bit for each of the three phases.
// ----------------------------------------------------------------------------
module fvp_div_cell import fvp_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] supply,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output div_type     out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic [31:0] dvs;

   assign in_ready = !valid_ff || out_ready;
   assign dvs      = {16'b0, supply} << BIT;

   // Subtract the shifted divisor where it fits and record the bit.
   always_comb begin
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         if (supply != 16'd0 && in_data.r[i] >= dvs) begin
            data_in.r[i]      = in_data.r[i] - dvs;
            data_in.q[i][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/foc_voltage_to_three_phase_pwm_core.sv -----
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the result side is ready; each
// stage has its own valid bit, so bubbles are squeezed out when it stalls.
// The quotient is formed by one restoring divider cell per bit.
// Reset clears all valid bits and sets the supply register to 3072 (12 V).
// ----------------------------------------------------------------------------
// FOC voltage to three phase PWM core
// Clamp, inverse Park, inverse Clarke and duty division to compare counts.
// ----------------------------------------------------------------------------
module foc_voltage_to_three_phase_pwm_core import fvp_pkg::*; #(
   parameter int PWM_PERIOD = 2400,
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int          QB    = $clog2(PWM_PERIOD + 1);
   localparam logic [31:0] AMASK = (32'd1 << ANGLE_BITS) - 32'd1;

   // Configuration register.
   logic [15:0] supply_ff;

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {16'b0, supply_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= 16'd3072;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         supply_ff <= pwdata[15:0];
      end
   end

   // Stage 0: double and clamp the voltage and fold both angles into the first quadrant.
   logic               s0_vld_ff, s0_rdy;
   logic signed [17:0] s0_v_ff, s0_v_in;
   logic [30:0]        s0_xs_ff, s0_xs_in, s0_xc_ff, s0_xc_in;
   logic               s0_ns_ff, s0_ns_in, s0_nc_ff, s0_nc_in;
   logic [31:0]        turn, turnc;
   logic signed [17:0] sup18;
   logic               s1_rdy;

   assign sup18 = $signed({2'b0, supply_ff});
   assign turn  = (({16'b0, req_data.electrical_angle}) & AMASK) << (32 - ANGLE_BITS);
   assign turnc = turn + QUARTER;

   always_comb begin
      s0_v_in = 18'(req_data.torque_voltage) <<< 1;
      if (s0_v_in > sup18) begin
         s0_v_in = sup18;
      end
      if (s0_v_in < -sup18) begin
         s0_v_in = -sup18;
      end
      s0_xs_in = {1'b0, turn[29:0]};
      if (turn[30]) begin
         s0_xs_in = 31'h4000_0000 - s0_xs_in;
      end
      s0_ns_in = turn[31];
      s0_xc_in = {1'b0, turnc[29:0]};
      if (turnc[30]) begin
         s0_xc_in = 31'h4000_0000 - s0_xc_in;
      end
      s0_nc_in = turnc[31];
   end

   assign s0_rdy    = !s0_vld_ff || s1_rdy;
   assign req_ready = s0_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_vld_ff <= req_valid;
      end
      if (s0_rdy && req_valid) begin
         s0_v_ff  <= s0_v_in;
         s0_xs_ff <= s0_xs_in;
         s0_xc_ff <= s0_xc_in;
         s0_ns_ff <= s0_ns_in;
         s0_nc_ff <= s0_nc_in;
      end
   end

   // Stage 1: square the folded arguments and seed the polynomial.
   logic     s1_vld_ff;
   horn_type s1_ff, s1_in;
   logic [4:0] h_vld, h_rdy;
   horn_type   h_data [5];

   always_comb begin
      s1_in.v     = s0_v_ff;
      s1_in.sl.x  = $signed({1'b0, s0_xs_ff});
      s1_in.sl.x2 = mul_q30($signed({1'b0, s0_xs_ff}), $signed({1'b0, s0_xs_ff}));
      s1_in.sl.p  = C9;
      s1_in.sl.neg = s0_ns_ff;
      s1_in.cl.x  = $signed({1'b0, s0_xc_ff});
      s1_in.cl.x2 = mul_q30($signed({1'b0, s0_xc_ff}), $signed({1'b0, s0_xc_ff}));
      s1_in.cl.p  = C9;
      s1_in.cl.neg = s0_nc_ff;
   end

   assign s1_rdy = !s1_vld_ff || h_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_vld_ff <= s0_vld_ff;
      end
      if (s1_rdy && s0_vld_ff) begin
         s1_ff <= s1_in;
      end
   end

   assign h_vld[0]  = s1_vld_ff;
   assign h_data[0] = s1_ff;

   // Four Horner cells, highest coefficient first.
   localparam logic signed [31:0] HCOEF [4] = '{C7, C5, C3, C1};
   logic s6_rdy;

   for (genvar i = 0; i < 4; i++) begin : g_horner
      fvp_horner_cell #(.COEF(HCOEF[i])) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (h_vld[i]),
         .in_ready  (h_rdy[i]),
         .in_data   (h_data[i]),
         .out_valid (h_vld[i+1]),
         .out_ready (h_rdy[i+1]),
         .out_data  (h_data[i+1])
      );
   end

   assign h_rdy[4] = s6_rdy;

   // Stage 6: final multiply by x, clamp to [0, 1] and apply the sign.
   logic               s6_vld_ff;
   logic signed [17:0] s6_v_ff;
   logic signed [31:0] s6_sn_ff, s6_sn_in, s6_cs_ff, s6_cs_in;
   logic signed [31:0] rs, rc;
   logic               s7_rdy;

   always_comb begin
      rs = mul_q30(h_data[4].sl.p, h_data[4].sl.x);
      rc = mul_q30(h_data[4].cl.p, h_data[4].cl.x);
      if (rs < 0) rs = '0;
      if (rs > ONE_Q30) rs = ONE_Q30;
      if (rc < 0) rc = '0;
      if (rc > ONE_Q30) rc = ONE_Q30;
      s6_sn_in = h_data[4].sl.neg ? -rs : rs;
      s6_cs_in = h_data[4].cl.neg ? -rc : rc;
   end

   assign s6_rdy = !s6_vld_ff || s7_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (s6_rdy) begin
         s6_vld_ff <= h_vld[4];
      end
      if (s6_rdy && h_vld[4]) begin
         s6_v_ff  <= h_data[4].v;
         s6_sn_ff <= s6_sn_in;
         s6_cs_ff <= s6_cs_in;
      end
   end

   // Stage 7: alpha and sqrt(3) times cosine.
   logic               s7_vld_ff;
   logic signed [17:0] s7_v_ff;
   logic signed [49:0] s7_a_ff;
   logic signed [31:0] s7_k_ff;
   logic               s8_rdy;

   assign s7_rdy = !s7_vld_ff || s8_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (s7_rdy) begin
         s7_vld_ff <= s6_vld_ff;
      end
      if (s7_rdy && s6_vld_ff) begin
         s7_v_ff <= s6_v_ff;
         s7_a_ff <= -(50'(s6_v_ff) * 50'(s6_sn_ff));
         s7_k_ff <= mul_q30(s6_cs_ff, SQRT3_Q30);
      end
   end

   // Stage 8: sqrt(3) times beta.
   logic               s8_vld_ff;
   logic signed [49:0] s8_a_ff, s8_bk_ff;
   logic               s9_rdy;

   assign s8_rdy = !s8_vld_ff || s9_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (s8_rdy) begin
         s8_vld_ff <= s7_vld_ff;
      end
      if (s8_rdy && s7_vld_ff) begin
         s8_a_ff  <= s7_a_ff;
         s8_bk_ff <= 50'(s7_v_ff) * 50'(s7_k_ff);
      end
   end

   // Stage 9: phase sums with half-supply offset, clamped to [0, supply].
   logic               s9_vld_ff;
   logic [2:0][47:0]   s9_u_ff, s9_u_in;
   logic signed [51:0] pa, pb, off;
   logic signed [51:0] n [3];
   logic [47:0]        top;
   logic               s10_rdy;

   assign top = {supply_ff, 32'b0};

   always_comb begin
      pa   = 52'(s8_a_ff);
      pb   = 52'(s8_bk_ff);
      off  = $signed({5'b0, supply_ff, 31'b0});
      n[0] = (pa <<< 1) + off;
      n[1] = pb - pa + off;
      n[2] = -pa - pb + off;
      for (int i = 0; i < 3; i++) begin
         if (supply_ff == 16'd0 || n[i] <= 0) begin
            s9_u_in[i] = '0;
         end else if (n[i] > $signed({4'b0, top})) begin
            s9_u_in[i] = top;
         end else begin
            s9_u_in[i] = n[i][47:0];
         end
      end
   end

   assign s9_rdy = !s9_vld_ff || s10_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (s9_rdy) begin
         s9_vld_ff <= s8_vld_ff;
      end
      if (s9_rdy && s8_vld_ff) begin
         s9_u_ff <= s9_u_in;
      end
   end

   // Stage 10: scale by the period; the low 32 bits cannot affect the quotient.
   logic    s10_vld_ff;
   div_type s10_ff, s10_in;
   logic [63:0] m [3];
   logic [QB:0] d_vld, d_rdy;
   div_type     d_data [QB+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m[i]         = {16'b0, s9_u_ff[i]} * 64'(PWM_PERIOD);
         s10_in.r[i]  = m[i][63:32];
         s10_in.q[i]  = '0;
      end
   end

   assign s10_rdy = !s10_vld_ff || d_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else if (s10_rdy) begin
         s10_vld_ff <= s9_vld_ff;
      end
      if (s10_rdy && s9_vld_ff) begin
         s10_ff <= s10_in;
      end
   end

   assign d_vld[0]  = s10_vld_ff;
   assign d_data[0] = s10_ff;

   // Divider chain, one quotient bit per cell, most significant first.
   for (genvar i = 0; i < QB; i++) begin : g_div
      fvp_div_cell #(.BIT(QB - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .supply    (supply_ff),
         .in_valid  (d_vld[i]),
         .in_ready  (d_rdy[i]),
         .in_data   (d_data[i]),
         .out_valid (d_vld[i+1]),
         .out_ready (d_rdy[i+1]),
         .out_data  (d_data[i+1])
      );
   end

   assign d_rdy[QB]          = rsp_ready;
   assign rsp_valid          = d_vld[QB];
   assign rsp_data.compare_a = d_data[QB].q[0][11:0];
   assign rsp_data.compare_b = d_data[QB].q[1][11:0];
   assign rsp_data.compare_c = d_data[QB].q[2][11:0];

   // The input only stalls when every cell is full behind a blocked result.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output backpressure");

   // Folded sine arguments never exceed one quarter turn.
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      s0_vld_ff |-> (s0_xs_ff <= 31'h4000_0000 && s0_xc_ff <= 31'h4000_0000))
      else $error("folded angle out of range");

   // Clamped phase numerators stay within the supply.
   a_phase_clamp: assert property (@(posedge clock) disable iff (reset)
      s9_vld_ff |-> (s9_u_ff[0] <= top && s9_u_ff[1] <= top && s9_u_ff[2] <= top))
      else $error("phase numerator above supply");

   // Final quotients never exceed the PWM period.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(d_data[QB].q[0]) <= 32'(PWM_PERIOD)
                  && 32'(d_data[QB].q[1]) <= 32'(PWM_PERIOD)
                  && 32'(d_data[QB].q[2]) <= 32'(PWM_PERIOD)))
      else $error("compare count above period");

endmodule

// ----- dv/foc_voltage_to_three_phase_pwm_core_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FOC voltage to PWM checker
// Watches the request and response channels and the register port, computes
// the expected compare counts for each accepted request and compares them
// in order with the accepted responses.
// ----------------------------------------------------------------------------
module foc_voltage_to_three_phase_pwm_core_checker import fvp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count,
   output int          rsp_seen
);

   localparam longint PERIOD = 2400;
   localparam longint K1 = 64'sd1686629713;
   localparam longint K3 = -64'sd693598668;
   localparam longint K5 = 64'sd85569306;
   localparam longint K7 = -64'sd5026995;
   localparam longint K9 = 64'sd172272;
   localparam longint ROOT3 = 64'sd1859775393;
   localparam longint UNIT = 64'sd1073741824;
   localparam logic [2:0] ADDR_SUPPLY = 3'd0;

   logic [15:0] supply;
   rsp_type     compare_queue[$];

   // Scaled product truncated toward zero.
   function automatic longint qmul(longint a, longint b);
      longint ma, mb, r;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      r  = (ma * mb) >>> 30;
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   // Sine of a 32-bit turn fraction by quadrant folding and a polynomial.
   function automatic longint turn_sine(logic [31:0] turn);
      longint x, x2, p, r;
      x = longint'(turn[29:0]);
      if (turn[30]) x = UNIT - x;
      x2 = qmul(x, x);
      p = K9;
      p = K7 + qmul(p, x2);
      p = K5 + qmul(p, x2);
      p = K3 + qmul(p, x2);
      p = K1 + qmul(p, x2);
      r = qmul(p, x);
      if (r < 0) r = 0;
      if (r > UNIT) r = UNIT;
      return turn[31] ? -r : r;
   endfunction

   function automatic logic [11:0] duty_count(longint n, logic [15:0] s);
      logic [63:0] top, u, q;
      top = {16'd0, s, 32'd0};
      if (s == 0 || n <= 0) return 12'd0;
      u = n;
      if (u > top) u = top;
      q = (u * PERIOD) / top;
      return q[11:0];
   endfunction

   function automatic rsp_type phase_compares(req_type r, logic [15:0] s);
      rsp_type     e;
      longint      v, sn, cs, k, a, bk, off;
      logic [31:0] turn;
      v = 2 * longint'(r.torque_voltage);
      if (v > longint'(s)) v = s;
      if (v < -longint'(s)) v = -longint'(s);
      turn = {r.electrical_angle, 16'd0};
      sn = turn_sine(turn);
      cs = turn_sine(turn + 32'h4000_0000);
      k = qmul(cs, ROOT3);
      a = -v * sn;
      bk = v * k;
      off = longint'(s) <<< 31;
      e.compare_a = duty_count(2 * a + off, s);
      e.compare_b = duty_count(bk - a + off, s);
      e.compare_c = duty_count(-a - bk + off, s);
      return e;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // Track the register, predict on request transactions, check responses.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         supply <= 16'd3072;
         fail_count = 0;
         rsp_seen = 0;
         compare_queue.delete();
         pending_count = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_SUPPLY)
            supply <= pwdata[15:0];
         if (req_valid && req_ready)
            compare_queue.push_back(phase_compares(req_data, supply));
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (compare_queue.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               e = compare_queue.pop_front();
               if (rsp_data.compare_a !== e.compare_a)
                  report_mismatch("compare_a", rsp_data.compare_a, e.compare_a);
               if (rsp_data.compare_b !== e.compare_b)
                  report_mismatch("compare_b", rsp_data.compare_b, e.compare_b);
               if (rsp_data.compare_c !== e.compare_c)
                  report_mismatch("compare_c", rsp_data.compare_c, e.compare_c);
            end
         end
         pending_count = compare_queue.size();
      end
   end

endmodule

// ----- dv/foc_voltage_to_three_phase_pwm_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FOC voltage to PWM testbench
// Drives directed and random voltage and angle requests through several
// supply settings and flow-control phases; the checker compares results.
// ----------------------------------------------------------------------------
module foc_voltage_to_three_phase_pwm_core_test;
   import fvp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [2:0] ADDR_SUPPLY = 3'd0;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending_count, rsp_seen;
   int          idle_pct, stall_pct;
   int          hold_off;
   int          quiet_cycles;
   int          sent;

   foc_voltage_to_three_phase_pwm_core DUT (.*);

   foc_voltage_to_three_phase_pwm_core_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Response side: random stall, plus an optional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on cycles with no transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("foc_voltage_to_three_phase_pwm_core test failed");
            $finish;
         end
      end
   end

   task automatic write_supply(logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_SUPPLY; pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // Valid drops only while the sender idles, so back-to-back transactions
   // never see two updates of valid in one time step.
   task automatic send_request(logic [15:0] voltage, logic [15:0] angle);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {voltage, angle};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_requests(int count);
      logic [15:0] v;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(600) - 300);
            2: v = $urandom_range(1) ? 16'(32'h7fff - $urandom_range(3))
                                     : 16'(32'h8000 + $urandom_range(3));
            default: v = 16'($urandom_range(8000) - 4000);
         endcase
         send_request(v, 16'($urandom));
      end
   endtask

   initial begin
      logic [15:0] supplies[6];
      supplies = '{16'd3072, 16'd1, 16'd65535, 16'd0, 16'd480, 16'd12345};
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      idle_pct = 0; stall_pct = 0; hold_off = 0; sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed corners at the reset supply, then at supplies of 0 and 65535.
      send_request(16'h0000, 16'h0000);
      send_request(16'h7fff, 16'h0000);
      send_request(16'h8000, 16'h0000);
      send_request(16'h0600, 16'h4000);
      send_request(16'hfa00, 16'h8000);
      send_request(16'h0600, 16'hc000);
      send_request(16'h0300, 16'hffff);
      send_request(16'h05ff, 16'h2aaa);
      send_request(16'hffff, 16'h5555);
      send_request(16'h0001, 16'h0001);
      drain();
      write_supply(16'd0);
      send_request(16'h7fff, 16'h1234);
      send_request(16'h8000, 16'hedcb);
      drain();
      write_supply(16'd65535);
      send_request(16'h7fff, 16'h0000);
      send_request(16'h8000, 16'h4000);
      send_request(16'h7fff, 16'haaaa);
      drain();

      // Random phases across supplies and flow-control settings.
      for (int ph = 0; ph < 6; ph++) begin
         write_supply(supplies[ph]);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 82; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         if (ph == 4) hold_off <= 300;
         random_requests(240);
         drain();
      end

      $display("sent %0d requests over six supply settings, %0d responses checked",
               sent, rsp_seen);
      if (fail_count == 0) begin
         $display("foc_voltage_to_three_phase_pwm_core test passed");
      end else begin
         $display("foc_voltage_to_three_phase_pwm_core test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fvp_pkg.sv
rtl/fvp_horner_cell.sv
rtl/fvp_div_cell.sv
rtl/foc_voltage_to_three_phase_pwm_core.sv
dv/foc_voltage_to_three_phase_pwm_core_checker.sv
dv/foc_voltage_to_three_phase_pwm_core_test.sv
